// ----- rtl/tcrpg_pkg.sv -----
package tcrpg_pkg;

  localparam int unsigned CODE_W    = 16;
  localparam int unsigned ATTR_W    = 8;
  localparam int unsigned GLYPH_W   = 8;
  localparam int unsigned ROW_W     = 5;
  localparam int unsigned BLINK_W   = 5;
  localparam int unsigned COLOR_W   = 4;
  localparam int unsigned NPIX      = GLYPH_W;
  localparam int unsigned PIXELS_W  = NPIX * COLOR_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATTR_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BG    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGHLIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_FONT  = 3'd3;

  localparam logic [2:0] ATTR_MODE_FLAG = 3'd1;

  // flag bits in the low attribute nibble (flag mode)
  localparam int unsigned FLAG_SECRET    = 0;
  localparam int unsigned FLAG_BLINK     = 1;
  localparam int unsigned FLAG_REVERSE   = 2;
  localparam int unsigned FLAG_HIGHLIGHT = 3;

  localparam logic [CODE_W-1:0]  CODE_NULL     = 16'h0000;
  localparam logic [CODE_W-1:0]  CODE_SPACE    = 16'h0020;
  localparam logic [1:0]         BLINK_OFF_PH  = 2'b01;

  typedef struct packed {
    logic [CODE_W-1:0]  char_code;
    logic [ATTR_W-1:0]  attribute;
    logic [GLYPH_W-1:0] font_row;
    logic [ROW_W-1:0]   row_in_line;
    logic [BLINK_W-1:0] blink_count;
  } cell_t;

  typedef struct packed {
    logic [PIXELS_W-1:0] pixels;
    logic                drawn;
  } result_t;

endpackage

// ----- rtl/tcrpg_if.sv -----
interface tcrpg_cell_if
  import tcrpg_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [CODE_W-1:0]  char_code;
  logic [ATTR_W-1:0]  attribute;
  logic [GLYPH_W-1:0] font_row;
  logic [ROW_W-1:0]   row_in_line;
  logic [BLINK_W-1:0] blink_count;

  modport source (output valid, char_code, attribute, font_row, row_in_line, blink_count,
                  input ready);
  modport sink (input valid, char_code, attribute, font_row, row_in_line, blink_count,
                output ready);
endinterface

interface tcrpg_pix_if
  import tcrpg_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [PIXELS_W-1:0] pixels;
  logic                drawn;

  modport source (output valid, pixels, drawn, input ready);
  modport sink (input valid, pixels, drawn, output ready);
endinterface

interface tcrpg_cfg_if
  import tcrpg_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/text_cell_row_pixel_generator.sv -----
// channel    role    payload
// cell_chan  sink    char_code, attribute, font_row, row_in_line, blink_count
// pix_chan   source  pixels, drawn
// cfg_chan   sink    index, data (register write, always ready)
//
// the cell passes two registers: input register, then result register
// one cell per cycle sustained while pix_chan is ready; the color/glyph logic sits between the two registers
// rst is synchronous and clears both valid flags and the config registers
// a stalled result holds in the result register while the input register still fills
// cell_chan.ready drops only when both registers hold an item and the result is stalled
module text_cell_row_pixel_generator
  import tcrpg_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  tcrpg_cell_if.sink   cell_chan,
  tcrpg_pix_if.source  pix_chan,
  tcrpg_cfg_if.sink    cfg_chan
);

  logic [2:0]         attr_mode;
  logic [COLOR_W-1:0] frame_background;
  logic [ROW_W-1:0]   highlight_row;
  logic               short_font;

  cell_t   cell_q;
  logic    cell_valid;
  result_t res_q;
  logic    res_valid;
  result_t res_next;

  logic advance;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr_mode        <= '0;
      frame_background <= '0;
      highlight_row    <= '0;
      short_font       <= 1'b0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_ATTR_MODE:  attr_mode        <= cfg_chan.data[2:0];
        REG_FRAME_BG:   frame_background <= cfg_chan.data[COLOR_W-1:0];
        REG_HIGHLIGHT:  highlight_row    <= cfg_chan.data[ROW_W-1:0];
        REG_SHORT_FONT: short_font       <= cfg_chan.data[0];
        default: ;
      endcase
    end
  end

  // result register moves when empty or taken
  assign advance         = !res_valid || pix_chan.ready;
  assign cell_chan.ready = !cell_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (cell_chan.ready) begin
        cell_valid <= cell_chan.valid;
      end
      if (advance) begin
        res_valid <= cell_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cell_chan.valid && cell_chan.ready) begin
      cell_q.char_code   <= cell_chan.char_code;
      cell_q.attribute   <= cell_chan.attribute;
      cell_q.font_row    <= cell_chan.font_row;
      cell_q.row_in_line <= cell_chan.row_in_line;
      cell_q.blink_count <= cell_chan.blink_count;
    end
    if (advance && cell_valid) begin
      res_q <= res_next;
    end
  end

  logic [COLOR_W-1:0] cbg, cfg_col, bg, fg, hl_color, fg_draw;
  logic [3:0]         flags;
  logic               blank, hl_line, in_font;

  always_comb begin
    if (attr_mode == ATTR_MODE_FLAG) begin
      cbg     = frame_background;
      cfg_col = cell_q.attribute[7:4];
      flags   = cell_q.attribute[3:0];
    end else begin
      cbg     = cell_q.attribute[7:4];
      cfg_col = cell_q.attribute[3:0];
      flags   = '0;
    end

    if (flags[FLAG_REVERSE]) begin
      bg = cfg_col;
      fg = cbg;
    end else begin
      bg = cbg;
      fg = cfg_col;
    end
    hl_color = fg;

    // secret, or blink in its off phase, hides the glyph
    if (flags[FLAG_SECRET] ||
        (flags[FLAG_BLINK] && cell_q.blink_count[4:3] == BLINK_OFF_PH)) begin
      fg_draw = bg;
    end else begin
      fg_draw = fg;
    end

    blank   = (cell_q.char_code == CODE_NULL || cell_q.char_code == CODE_SPACE) &&
              bg == '0 && !flags[FLAG_HIGHLIGHT];
    hl_line = flags[FLAG_HIGHLIGHT] && cell_q.row_in_line == highlight_row;
    // row < 8 or row < 16
    in_font = !cell_q.row_in_line[4] && !(short_font && cell_q.row_in_line[3]);

    res_next.drawn = !blank;
    for (int i = 0; i < NPIX; i++) begin
      priority if (blank) begin
        res_next.pixels[PIXELS_W-1-COLOR_W*i -: COLOR_W] = '0;
      end else if (hl_line) begin
        res_next.pixels[PIXELS_W-1-COLOR_W*i -: COLOR_W] = hl_color;
      end else if (in_font && cell_q.font_row[GLYPH_W-1-i]) begin
        res_next.pixels[PIXELS_W-1-COLOR_W*i -: COLOR_W] = fg_draw;
      end else begin
        res_next.pixels[PIXELS_W-1-COLOR_W*i -: COLOR_W] = bg;
      end
    end
  end

  assign pix_chan.valid  = res_valid;
  assign pix_chan.pixels = res_q.pixels;
  assign pix_chan.drawn  = res_q.drawn;

endmodule

// ----- rtl/tcrpg_checker.sv -----
module tcrpg_checker
  import tcrpg_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                cell_valid,
  input logic                cell_ready,
  input logic                pix_valid,
  input logic                pix_ready,
  input logic [PIXELS_W-1:0] pixels,
  input logic                drawn
);

  // a stalled result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> pix_valid && $stable(pixels) && $stable(drawn))
    else $error("result changed while stalled");

  // a skipped blank cell shows all zeros
  a_blank_zero: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !drawn |-> pixels == '0)
    else $error("blank cell with nonzero pixels");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !pix_valid)
    else $error("result valid after reset");

  // an accepted cell reaches the output when the sink is ready while it sits in the input register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    cell_valid && cell_ready ##1 pix_ready |=> pix_valid)
    else $error("accepted cell did not reach the output");

endmodule

bind text_cell_row_pixel_generator tcrpg_checker u_tcrpg_checker (
  .clk        (clk),
  .rst        (rst),
  .cell_valid (cell_chan.valid),
  .cell_ready (cell_chan.ready),
  .pix_valid  (pix_chan.valid),
  .pix_ready  (pix_chan.ready),
  .pixels     (pix_chan.pixels),
  .drawn      (pix_chan.drawn)
);
